// ----- rtl/gss_pkg.sv -----
// Shared types, constants and helpers for the GIF structure scanner.
// Used by gss_step and gif_structure_scanner_unit; depends on nothing.
package gss_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int FIELD_W     = 10;
	localparam int OUT_LEN_W   = 32;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	typedef enum logic [3:0] {
		PH_SIG      = 4'd0,
		PH_SCREEN   = 4'd1,
		PH_GTABLE   = 4'd2,
		PH_INTRO    = 4'd3,
		PH_IMGDESC  = 4'd4,
		PH_LTABLE   = 4'd5,
		PH_CODESIZE = 4'd6,
		PH_EXTLABEL = 4'd7,
		PH_SUBSIZE  = 4'd8,
		PH_SUBDATA  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		V_MATCHED  = 2'd0,
		V_NOMATCH  = 2'd1,
		V_PARTIAL  = 2'd2,
		V_NEEDMORE = 2'd3
	} verdict_t;

	localparam logic [7:0] CH_G       = 8'h47;
	localparam logic [7:0] CH_I       = 8'h49;
	localparam logic [7:0] CH_F       = 8'h46;
	localparam logic [7:0] CH_8       = 8'h38;
	localparam logic [7:0] CH_7       = 8'h37;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_A       = 8'h61;
	localparam logic [7:0] TRAILER    = 8'h3B;
	localparam logic [7:0] IMAGE_SEP  = 8'h2C;
	localparam logic [7:0] EXT_INTRO  = 8'h21;

	localparam logic [LENGTH_BITS-1:0] SIG_LAST_IDX    = LENGTH_BITS'(5);
	localparam logic [LENGTH_BITS-1:0] SCR_PACKED_IDX  = LENGTH_BITS'(10);
	localparam logic [LENGTH_BITS-1:0] SCR_LAST_IDX    = LENGTH_BITS'(12);
	localparam logic [FIELD_W-1:0]     IMG_DESC_BYTES  = FIELD_W'(9);

	typedef struct packed {
		phase_t                   phase;
		logic [FIELD_W-1:0]       field;
		logic [LENGTH_BITS-1:0]   len;
	} scan_state_t;

	typedef struct packed {
		logic                     emit;
		verdict_t                 verdict;
		logic [OUT_LEN_W-1:0]     length;
		logic [3:0]               reason;
	} scan_result_t;

	function automatic logic [FIELD_W-1:0] table_size(input logic [7:0] packed_byte);
		logic [FIELD_W-1:0] sz;
		sz = '0;
		if (packed_byte[7]) begin
			sz = (FIELD_W'(3) << packed_byte[2:0]) << 1;
		end
		return sz;
	endfunction

	function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LENGTH_BITS-1:0] len);
		logic [LENGTH_BITS+OUT_LEN_W-1:0] ext;
		logic [OUT_LEN_W-1:0]             res;
		ext = {{OUT_LEN_W{1'b0}}, len};
		if (ext[LENGTH_BITS+OUT_LEN_W-1:OUT_LEN_W] != '0) begin
			res = '1;
		end else begin
			res = ext[OUT_LEN_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/gss_step.sv -----
// One parse step of the GIF structure scanner: next state and verdict for one beat.
// Purely combinational; depends on gss_pkg.
module gss_step
	import gss_pkg::*;
(
	input  scan_state_t  cur,
	input  logic [7:0]   data_byte,
	input  logic         end_of_data,
	input  logic         final_chunk,
	output scan_state_t  nxt,
	output scan_result_t res
);

	logic [LENGTH_BITS-1:0] len_inc;
	logic                   sig_ok;
	logic                   field_last;

	assign len_inc    = (cur.len == LEN_MAX) ? cur.len : cur.len + LENGTH_BITS'(1);
	assign field_last = (cur.field <= FIELD_W'(1));

	always_comb begin
		unique case (cur.len[2:0])
			3'd0:    sig_ok = (data_byte == CH_G);
			3'd1:    sig_ok = (data_byte == CH_I);
			3'd2:    sig_ok = (data_byte == CH_F);
			3'd3:    sig_ok = (data_byte == CH_8);
			3'd4:    sig_ok = (data_byte == CH_7) || (data_byte == CH_9);
			3'd5:    sig_ok = (data_byte == CH_A);
			default: sig_ok = 1'b0;
		endcase
		if (cur.len > SIG_LAST_IDX) begin
			sig_ok = 1'b0;
		end
	end

	always_comb begin
		nxt         = cur;
		res.emit    = 1'b0;
		res.verdict = V_NOMATCH;
		res.length  = '0;
		res.reason  = '0;
		if (end_of_data) begin
			res.emit = 1'b1;
			if (cur.phase == PH_SIG) begin
				if (cur.len != '0 && !final_chunk) begin
					res.verdict = V_NEEDMORE;
				end else begin
					nxt = '{phase: PH_SIG, field: '0, len: '0};
				end
			end else if (!final_chunk) begin
				res.verdict = V_NEEDMORE;
			end else begin
				res.verdict = V_PARTIAL;
				res.length  = sat_len(cur.len);
				res.reason  = 4'(cur.phase);
				nxt         = '{phase: PH_SIG, field: '0, len: '0};
			end
		end else begin
			nxt.len = len_inc;
			unique case (cur.phase)
				PH_SIG: begin
					if (!sig_ok) begin
						res.emit = 1'b1;
						nxt      = '{phase: PH_SIG, field: '0, len: '0};
					end else if (cur.len == SIG_LAST_IDX) begin
						nxt.phase = PH_SCREEN;
					end
				end
				PH_SCREEN: begin
					if (cur.len == SCR_PACKED_IDX) begin
						nxt.field = table_size(data_byte);
					end
					if (cur.len >= SCR_LAST_IDX) begin
						nxt.phase = (cur.field != '0) ? PH_GTABLE : PH_INTRO;
					end
				end
				PH_GTABLE, PH_LTABLE: begin
					if (field_last) begin
						nxt.field = '0;
						nxt.phase = (cur.phase == PH_GTABLE) ? PH_INTRO : PH_CODESIZE;
					end else begin
						nxt.field = cur.field - FIELD_W'(1);
					end
				end
				PH_INTRO: begin
					if (data_byte == TRAILER) begin
						res.emit    = 1'b1;
						res.verdict = V_MATCHED;
						res.length  = sat_len(len_inc);
						nxt         = '{phase: PH_SIG, field: '0, len: '0};
					end else if (data_byte == IMAGE_SEP) begin
						nxt.phase = PH_IMGDESC;
						nxt.field = IMG_DESC_BYTES;
					end else if (data_byte == EXT_INTRO) begin
						nxt.phase = PH_EXTLABEL;
					end else begin
						res.emit = 1'b1;
						nxt      = '{phase: PH_SIG, field: '0, len: '0};
					end
				end
				PH_IMGDESC: begin
					if (field_last) begin
						nxt.field = table_size(data_byte);
						nxt.phase = (table_size(data_byte) != '0) ? PH_LTABLE : PH_CODESIZE;
					end else begin
						nxt.field = cur.field - FIELD_W'(1);
					end
				end
				PH_CODESIZE, PH_EXTLABEL: begin
					nxt.phase = PH_SUBSIZE;
				end
				PH_SUBSIZE: begin
					if (data_byte == 8'h00) begin
						nxt.phase = PH_INTRO;
					end else begin
						nxt.field = FIELD_W'(data_byte);
						nxt.phase = PH_SUBDATA;
					end
				end
				PH_SUBDATA: begin
					if (field_last) begin
						nxt.field = '0;
						nxt.phase = PH_SUBSIZE;
					end else begin
						nxt.field = cur.field - FIELD_W'(1);
					end
				end
				default: begin
					nxt = '{phase: PH_SIG, field: '0, len: '0};
				end
			endcase
		end
	end

endmodule

// ----- rtl/gif_structure_scanner_unit.sv -----
// Top level of the GIF structure scanner: input register, parse state, result register.
// Depends on gss_pkg and gss_step.
//
// Usage: feed the stream one beat per cycle on the in channel (in_valid/in_ready),
// starting at a candidate signature. A beat carries data_byte, or, with end_of_data
// set, marks the end of the available data (final_chunk says whether more follows).
// Results leave on the out channel (out_valid/out_ready): verdict, byte_length and
// truncation_reason. Beats that end nothing give no result.
// A result is offered once its input beat has moved from the input register into the
// result register. Throughput: one beat per cycle while the receiver takes results;
// the parse state is updated by one pass of logic from the input register.
// When the receiver stalls with a result held, the input register holds its beat
// and in_ready falls once it is full; no beat is lost.
// Reset clears both registers' valid flags and puts the parser back to looking
// for the first signature byte with a zero byte count.
module gif_structure_scanner_unit
	import gss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	input  logic        final_chunk,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [31:0] byte_length,
	output logic [3:0]  truncation_reason
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eod_s1;
	logic         fin_s1;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t step_res;
	logic         out_valid_q;
	verdict_t     verdict_q;
	logic [31:0]  length_q;
	logic [3:0]   reason_q;
	logic         advance;
	logic         fire;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	gss_step u_step (
		.cur         (state_q),
		.data_byte   (byte_s1),
		.end_of_data (eod_s1),
		.final_chunk (fin_s1),
		.nxt         (state_nxt),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_data;
			fin_s1  <= final_chunk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SIG, field: '0, len: '0};
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && step_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_res.emit) begin
			verdict_q <= step_res.verdict;
			length_q  <= step_res.length;
			reason_q  <= step_res.reason;
		end
	end

	assign out_valid         = out_valid_q;
	assign verdict           = verdict_q;
	assign byte_length       = length_q;
	assign truncation_reason = reason_q;

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready)
		else $error("input stalled while result register free");

	a_sig_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_SIG |-> state_q.field == '0 && state_q.len <= SIG_LAST_IDX)
		else $error("signature phase with stale count");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_SUBDATA || state_q.phase == PH_GTABLE ||
		 state_q.phase == PH_LTABLE) |-> state_q.field != '0)
		else $error("counted phase entered with zero bytes");

	a_matched_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q == V_MATCHED |-> reason_q == '0 && length_q >= 32'd14)
		else $error("matched verdict with bad length or reason");

endmodule
